### rtl/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants for the set pair disjointness core.
// ----------------------------------------------------------------------------
package spd_pkg;

    // Fixed field widths of the input beat
    localparam int unsigned SET_W  = 10;
    localparam int unsigned POS_W  = 5;
    localparam int unsigned LINE_W = 16;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_IDX1,
        S_IDX2,
        S_IDX3,
        S_WRITE,
        S_READ,
        S_DRAIN,
        S_RESULT
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic capture;    // latch input beat
        logic ptr_load;   // load set base pointers, clear compare state
        logic wr_en;      // write one element
        logic rd_en;      // read one element of each set, advance pointers
        logic ld_result;  // load output register
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic is_query;
        logic pos_ok;
    } t_status;

endpackage

### rtl/spd_ram.sv
// ----------------------------------------------------------------------------
// spd_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module spd_ram #(
    parameter int unsigned WIDTH  = 16,
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr_a,
    input  logic [ADDR_W-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]  o_rd_data_a,
    output logic [WIDTH-1:0]  o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

### rtl/spd_ctrl.sv
// ----------------------------------------------------------------------------
// spd_ctrl
// Sequencer: index math, element write, set scan, result handoff.
// ----------------------------------------------------------------------------
module spd_ctrl #(
    parameter int unsigned SET_SLOTS = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  spd_pkg::t_status i_status,
    output spd_pkg::t_cmd    o_cmd
);

    localparam int unsigned CNT_W = (SET_SLOTS > 1) ? $clog2(SET_SLOTS) : 1;

    spd_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             last_rd;
    logic             res_go;

    assign last_rd = (32'(r_cnt) == SET_SLOTS - 1);
    assign res_go  = (r_state == spd_pkg::S_RESULT) && (!r_out_valid || i_out_ready);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spd_pkg::S_IDLE:   if (i_in_valid) n_state = spd_pkg::S_IDX1;
            spd_pkg::S_IDX1:   n_state = spd_pkg::S_IDX2;
            spd_pkg::S_IDX2:   n_state = spd_pkg::S_IDX3;
            spd_pkg::S_IDX3:   n_state = i_status.is_query ? spd_pkg::S_READ
                                                           : spd_pkg::S_WRITE;
            spd_pkg::S_WRITE:  n_state = spd_pkg::S_IDLE;
            spd_pkg::S_READ:   if (last_rd) n_state = spd_pkg::S_DRAIN;
            spd_pkg::S_DRAIN:  n_state = spd_pkg::S_RESULT;
            spd_pkg::S_RESULT: if (res_go) n_state = spd_pkg::S_IDLE;
            default:           n_state = spd_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready      = (r_state == spd_pkg::S_IDLE);
        o_cmd           = '0;
        o_cmd.capture   = (r_state == spd_pkg::S_IDLE) && i_in_valid;
        o_cmd.ptr_load  = (r_state == spd_pkg::S_IDX3);
        o_cmd.wr_en     = (r_state == spd_pkg::S_WRITE) && i_status.pos_ok;
        o_cmd.rd_en     = (r_state == spd_pkg::S_READ);
        o_cmd.ld_result = res_go;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (r_state == spd_pkg::S_IDX3) begin
            n_cnt = '0;
        end else if (r_state == spd_pkg::S_READ) begin
            n_cnt = r_cnt + CNT_W'(1);
        end
        n_out_valid = r_out_valid;
        if (res_go) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spd_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

### rtl/spd_datapath.sv
// ----------------------------------------------------------------------------
// spd_datapath
// Set index reduction, element store, pairwise compare, result register.
// ----------------------------------------------------------------------------
module spd_datapath #(
    parameter int unsigned MAX_SETS  = 1024,
    parameter int unsigned SET_SLOTS = 17,
    parameter int unsigned LINE_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  spd_pkg::t_cmd              i_cmd,
    output spd_pkg::t_status           o_status,
    input  logic                       i_kind,
    input  logic [spd_pkg::SET_W-1:0]  i_first_set,
    input  logic [spd_pkg::POS_W-1:0]  i_position,
    input  logic [spd_pkg::LINE_W-1:0] i_line_value,
    input  logic [spd_pkg::SET_W-1:0]  i_second_set,
    output logic                       o_disjoint
);

    localparam int unsigned DEPTH  = MAX_SETS * SET_SLOTS;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // Reciprocal for set index modulo MAX_SETS (exact for 10-bit indexes)
    localparam int unsigned     RSH  = spd_pkg::SET_W + $clog2(MAX_SETS);
    localparam longint unsigned RMUL = ((64'd1 << RSH) + MAX_SETS - 1) / MAX_SETS;

    // Captured beat
    logic                       r_kind;
    logic [spd_pkg::SET_W-1:0]  r_first;
    logic [spd_pkg::SET_W-1:0]  r_second;
    logic [spd_pkg::POS_W-1:0]  r_pos;
    logic [LINE_BITS-1:0]       r_line;

    // Index reduction pipeline
    logic [31:0]                r_prod_a, r_prod_b;
    logic [spd_pkg::SET_W-1:0]  r_qd_a, r_qd_b;
    logic [spd_pkg::SET_W-1:0]  rem_a, rem_b, remc_a, remc_b;
    logic [ADDR_W-1:0]          base_a, base_b;

    logic [ADDR_W-1:0]          r_ptr_a, r_ptr_b;
    logic [LINE_BITS-1:0]       rd_a, rd_b;

    // Compare state: elements seen so far, shifted in as they arrive
    logic [LINE_BITS-1:0]       r_hist_a [SET_SLOTS];
    logic [LINE_BITS-1:0]       r_hist_b [SET_SLOTS];
    logic [SET_SLOTS-1:0]       r_hv_a, r_hv_b;
    logic                       r_rd_valid;
    logic                       r_hit, n_hit;
    logic                       r_disjoint;
    logic                       match;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= i_kind;
            r_first  <= i_first_set;
            r_second <= i_second_set;
            r_pos    <= i_position;
            r_line   <= LINE_BITS'(i_line_value);
        end
        r_prod_a <= 32'(r_first) * 32'(RMUL);
        r_prod_b <= 32'(r_second) * 32'(RMUL);
        r_qd_a   <= spd_pkg::SET_W'(32'(r_prod_a >> RSH) * 32'(MAX_SETS));
        r_qd_b   <= spd_pkg::SET_W'(32'(r_prod_b >> RSH) * 32'(MAX_SETS));
    end

    always_comb begin
        rem_a  = r_first - r_qd_a;
        rem_b  = r_second - r_qd_b;
        remc_a = (32'(rem_a) >= MAX_SETS) ? spd_pkg::SET_W'(32'(rem_a) - MAX_SETS) : rem_a;
        remc_b = (32'(rem_b) >= MAX_SETS) ? spd_pkg::SET_W'(32'(rem_b) - MAX_SETS) : rem_b;
        base_a = ADDR_W'(32'(remc_a) * 32'(SET_SLOTS));
        base_b = ADDR_W'(32'(remc_b) * 32'(SET_SLOTS));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ptr_load) begin
            r_ptr_a <= base_a;
            r_ptr_b <= base_b;
        end else if (i_cmd.rd_en) begin
            r_ptr_a <= r_ptr_a + ADDR_W'(1);
            r_ptr_b <= r_ptr_b + ADDR_W'(1);
        end
    end

    spd_ram #(
        .WIDTH  (LINE_BITS),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (i_cmd.wr_en),
        .i_wr_addr   (r_ptr_a + ADDR_W'(r_pos)),
        .i_wr_data   (r_line),
        .i_rd_en     (i_cmd.rd_en),
        .i_rd_addr_a (r_ptr_a),
        .i_rd_addr_b (r_ptr_b),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    // New A element vs B elements so far (and the new B), new B vs older A.
    always_comb begin
        match = (rd_a == rd_b);
        for (int j = 0; j < SET_SLOTS; j++) begin
            match = match | (r_hv_b[j] && (r_hist_b[j] == rd_a))
                          | (r_hv_a[j] && (r_hist_a[j] == rd_b));
        end
        n_hit = r_hit | (r_rd_valid & match);
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_valid) begin
            r_hist_a[0] <= rd_a;
            r_hist_b[0] <= rd_b;
            for (int j = 1; j < SET_SLOTS; j++) begin
                r_hist_a[j] <= r_hist_a[j-1];
                r_hist_b[j] <= r_hist_b[j-1];
            end
        end
        if (i_cmd.ld_result) begin
            r_disjoint <= ~r_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_hit      <= 1'b0;
            r_hv_a     <= '0;
            r_hv_b     <= '0;
        end else begin
            r_rd_valid <= i_cmd.rd_en;
            if (i_cmd.ptr_load) begin
                r_hit  <= 1'b0;
                r_hv_a <= '0;
                r_hv_b <= '0;
            end else begin
                r_hit <= n_hit;
                if (r_rd_valid) begin
                    r_hv_a <= SET_SLOTS'({r_hv_a, 1'b1});
                    r_hv_b <= SET_SLOTS'({r_hv_b, 1'b1});
                end
            end
        end
    end

    assign o_status.is_query = (r_kind == spd_pkg::KIND_QUERY);
    assign o_status.pos_ok   = (32'(r_pos) < SET_SLOTS);
    assign o_disjoint        = r_disjoint;

endmodule

### rtl/set_pair_disjointness_core.sv
// ----------------------------------------------------------------------------
// set_pair_disjointness_core
// Table of fixed-size sets of line identifiers with pairwise disjoint test.
// ----------------------------------------------------------------------------
// A write beat (kind 0) stores one identifier into slot position of set
// first_set and returns nothing; slots at or beyond SET_SLOTS are dropped and
// set indexes wrap modulo MAX_SETS. A query beat (kind 1) returns one beat
// with disjoint = 1 when sets first_set and second_set share no identifier.
// Every set must be fully written before it is queried; the store is not
// cleared at reset. A write passes the index reduction and one write state;
// a query's duration is set by the scan of both sets through the two read
// ports of the set store, one element of each set per cycle, after the set
// index reduction in states S_IDX1, S_IDX2 and S_IDX3.
// A finished result sits in an output register, so the next beat is taken
// while the result still waits for o_out_valid/i_out_ready.
// ----------------------------------------------------------------------------
module set_pair_disjointness_core #(
    parameter int unsigned MAX_SETS  = 1024,
    parameter int unsigned SET_SLOTS = 17,
    parameter int unsigned LINE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [9:0]  i_first_set,
    input  logic [4:0]  i_position,
    input  logic [15:0] i_line_value,
    input  logic [9:0]  i_second_set,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_disjoint
);

    spd_pkg::t_cmd    cmd;
    spd_pkg::t_status status;

    // Sequencer: owns state, scan counter and result valid
    spd_ctrl #(
        .SET_SLOTS (SET_SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Datapath: index math, set store, compare history, result bit
    spd_datapath #(
        .MAX_SETS  (MAX_SETS),
        .SET_SLOTS (SET_SLOTS),
        .LINE_BITS (LINE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_kind       (i_kind),
        .i_first_set  (i_first_set),
        .i_position   (i_position),
        .i_line_value (i_line_value),
        .i_second_set (i_second_set),
        .o_disjoint   (o_disjoint)
    );

endmodule
